### design/vertex_weld_table_macros.svh
// assertion macros used by the checker file
`ifndef VERTEX_WELD_TABLE_MACROS_SVH
`define VERTEX_WELD_TABLE_MACROS_SVH

// consequent must hold in the same cycle as the antecedent
`define VWT_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("vertex weld table assertion failed");

// consequent must hold in the cycle after the antecedent
`define VWT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("vertex weld table assertion failed");

`endif

### design/vwt_pkg.sv
`timescale 1ns / 1ps
package vwt_pkg;

	localparam int TABLE_DEPTH_DEF = 1024;
	localparam int COORD_WIDTH_DEF = 16;
	localparam int INDEX_W_DEF     = 10;
	localparam int THR_W           = 36;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_APPEND,
		ST_RESP
	} weld_state_t;

	// status of the distance pipeline seen by the sequencer
	typedef struct packed {
		logic busy;
		logic vld;
		logic hit;
	} scan_flags_t;

endpackage

### design/vwt_ifs.sv
`timescale 1ns / 1ps
interface vwt_vertex_if import vwt_pkg::*; #(
	parameter int CW = COORD_WIDTH_DEF
) ();
	logic                 valid;
	logic                 ready;
	logic signed [CW-1:0] x_coord;
	logic signed [CW-1:0] y_coord;
	logic signed [CW-1:0] z_coord;
	logic                 batch_last;

	modport source (output valid, x_coord, y_coord, z_coord, batch_last, input ready);
	modport sink (input valid, x_coord, y_coord, z_coord, batch_last, output ready);
endinterface

interface vwt_result_if import vwt_pkg::*; #(
	parameter int IW = INDEX_W_DEF
) ();
	logic          valid;
	logic          ready;
	logic [IW-1:0] vertex_index;
	logic          added;
	logic          table_full;
	logic          batch_end;

	modport source (output valid, vertex_index, added, table_full, batch_end, input ready);
	modport sink (input valid, vertex_index, added, table_full, batch_end, output ready);
endinterface

interface vwt_cfg_if import vwt_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [THR_W-1:0] data;

	modport source (output valid, data, input ready);
	modport sink (input valid, data, output ready);
endinterface

### design/vwt_store.sv
`timescale 1ns / 1ps
module vwt_store import vwt_pkg::*; #(
	parameter int DEPTH = TABLE_DEPTH_DEF,
	parameter int W     = 3 * COORD_WIDTH_DEF
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [W-1:0]             wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [W-1:0]             rd_data
);

	logic [W-1:0] store_mem [DEPTH];
	logic [W-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			store_mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= store_mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

### design/vwt_dist.sv
`timescale 1ns / 1ps
module vwt_dist import vwt_pkg::*; #(
	parameter int CW = COORD_WIDTH_DEF,
	parameter int AW = 10
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              flush,
	input  logic              vld_s1,
	input  logic [AW-1:0]     idx_s1,
	input  logic [3*CW-1:0]   entry_s1,
	input  logic [3*CW-1:0]   vtx,
	input  logic [THR_W-1:0]  thr,
	output scan_flags_t       flags,
	output logic [AW-1:0]     hit_idx
);

	localparam int SQ_W  = 2 * CW + 1;
	localparam int SUM_W = SQ_W + 2;
	localparam int CMP_W = (SUM_W > THR_W) ? SUM_W : THR_W;

	logic signed [CW:0]     ent_x  [3];
	logic signed [CW:0]     vtx_x  [3];
	logic signed [CW:0]     diff   [3];
	logic signed [2*CW+1:0] prod   [3];
	logic [SQ_W-1:0]        sq_d   [3];
	logic [SQ_W-1:0]        sq_s2  [3];
	logic [SUM_W-1:0]       sum_s2;
	logic                   vld_s2;
	logic [AW-1:0]          idx_s2;
	logic                   vld_s3;
	logic                   hit_s3;
	logic [AW-1:0]          idx_s3;

	// per-axis difference and square, one multiplier per axis
	always_comb begin
		for (int k = 0; k < 3; k++) begin
			ent_x[k] = $signed({entry_s1[k*CW+CW-1], entry_s1[k*CW +: CW]});
			vtx_x[k] = $signed({vtx[k*CW+CW-1], vtx[k*CW +: CW]});
			diff[k]  = ent_x[k] - vtx_x[k];
			prod[k]  = diff[k] * diff[k];
			sq_d[k]  = prod[k][SQ_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			vld_s2 <= vld_s1 && !flush;
			vld_s3 <= vld_s2 && !flush;
		end
	end

	assign sum_s2 = SUM_W'(sq_s2[0]) + SUM_W'(sq_s2[1]) + SUM_W'(sq_s2[2]);

	always_ff @(posedge clk) begin
		sq_s2  <= sq_d;
		idx_s2 <= idx_s1;
		hit_s3 <= CMP_W'(sum_s2) < CMP_W'(thr);
		idx_s3 <= idx_s2;
	end

	assign flags.busy = vld_s2 || vld_s3;
	assign flags.vld  = vld_s3;
	assign flags.hit  = hit_s3;
	assign hit_idx    = idx_s3;

endmodule

### design/vertex_weld_table.sv
`timescale 1ns / 1ps
// channel      direction  holds
// cfg          in         match_threshold_sq write data
// vertex_in    in         x_coord, y_coord, z_coord, batch_last
// result_out   out        vertex_index, added, table_full, batch_end
//
// a vertex walks the stored entries one per cycle through the distance pipeline
// a match at entry i goes from the store read through the two distance stages into the result and output registers
// a new vertex scans every stored entry through the single read port unless a match ends the scan
// reset clears the state, entry count, threshold and valid flags, stored entries need no clearing
// vertex_in ready stays low while a vertex is in work; a stalled result holds the output
module vertex_weld_table import vwt_pkg::*; #(
	parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
	parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	vwt_cfg_if.sink         cfg,
	vwt_vertex_if.sink      vertex_in,
	vwt_result_if.source    result_out
);

	localparam int AW    = $clog2(TABLE_DEPTH);
	localparam int IW    = AW;
	localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
	localparam int VW    = 3 * COORD_WIDTH;

	weld_state_t      state_q, state_d;
	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] rd_idx_q;
	logic [THR_W-1:0] thr_q;
	logic [VW-1:0]    vtx_q;
	logic             last_q;
	logic [AW-1:0]    res_idx_q;
	logic             res_added_q;
	logic             res_full_q;

	logic             out_valid_q;
	logic [IW-1:0]    out_idx_q;
	logic             out_added_q;
	logic             out_full_q;
	logic             out_end_q;

	logic             rd_vld_s1;
	logic [AW-1:0]    rd_idx_s1;
	logic [VW-1:0]    entry_s1;

	scan_flags_t      flags;
	logic [AW-1:0]    hit_idx;

	logic             accept;
	logic             issue;
	logic             hit_take;
	logic             scan_done;
	logic             flush;
	logic             room;
	logic             store_wr;
	logic             resp_load;

	// config channel never stalls
	assign cfg.ready = 1'b1;

	assign vertex_in.ready = (state_q == ST_IDLE);
	assign accept          = vertex_in.valid && vertex_in.ready;

	// read the next entry while entries remain and no match has come out
	assign hit_take  = (state_q == ST_SCAN) && flags.vld && flags.hit;
	assign issue     = (state_q == ST_SCAN) && (rd_idx_q < count_q) && !hit_take;
	// later entries in flight are dropped once the first match shows up
	assign flush     = (state_q != ST_SCAN) || hit_take;
	assign scan_done = (state_q == ST_SCAN) && (rd_idx_q == count_q)
		&& !rd_vld_s1 && !flags.busy;

	assign room      = count_q < CNT_W'(TABLE_DEPTH);
	assign store_wr  = (state_q == ST_APPEND) && room;
	assign resp_load = (state_q == ST_RESP) && (!out_valid_q || result_out.ready);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				priority if (hit_take) begin
					state_d = ST_RESP;
				end else if (scan_done) begin
					state_d = ST_APPEND;
				end
			end
			ST_APPEND: begin
				state_d = ST_RESP;
			end
			ST_RESP: begin
				if (resp_load) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			thr_q       <= '0;
			rd_vld_s1   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg.valid) begin
				thr_q <= cfg.data;
			end
			if (store_wr) begin
				count_q <= count_q + CNT_W'(1);
			end
			rd_vld_s1 <= issue;
			if (resp_load) begin
				out_valid_q <= 1'b1;
			end else if (result_out.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			vtx_q    <= {vertex_in.z_coord, vertex_in.y_coord, vertex_in.x_coord};
			last_q   <= vertex_in.batch_last;
			rd_idx_q <= '0;
		end else if (issue) begin
			rd_idx_q <= rd_idx_q + CNT_W'(1);
		end
		rd_idx_s1 <= rd_idx_q[AW-1:0];
		if (hit_take) begin
			res_idx_q   <= hit_idx;
			res_added_q <= 1'b0;
			res_full_q  <= 1'b0;
		end else if (state_q == ST_APPEND) begin
			// no match: append, or report full with index zero
			res_idx_q   <= room ? count_q[AW-1:0] : '0;
			res_added_q <= room;
			res_full_q  <= !room;
		end
		if (resp_load) begin
			out_idx_q   <= res_idx_q;
			out_added_q <= res_added_q;
			out_full_q  <= res_full_q;
			out_end_q   <= last_q;
		end
	end

	vwt_store #(
		.DEPTH (TABLE_DEPTH),
		.W     (VW)
	) u_store (
		.clk     (clk),
		.wr_en   (store_wr),
		.wr_addr (count_q[AW-1:0]),
		.wr_data (vtx_q),
		.rd_en   (issue),
		.rd_addr (rd_idx_q[AW-1:0]),
		.rd_data (entry_s1)
	);

	vwt_dist #(
		.CW (COORD_WIDTH),
		.AW (AW)
	) u_dist (
		.clk      (clk),
		.arst_n   (arst_n),
		.flush    (flush),
		.vld_s1   (rd_vld_s1),
		.idx_s1   (rd_idx_s1),
		.entry_s1 (entry_s1),
		.vtx      (vtx_q),
		.thr      (thr_q),
		.flags    (flags),
		.hit_idx  (hit_idx)
	);

	assign result_out.valid        = out_valid_q;
	assign result_out.vertex_index = out_idx_q;
	assign result_out.added        = out_added_q;
	assign result_out.table_full   = out_full_q;
	assign result_out.batch_end    = out_end_q;

endmodule

### design/vwt_checker.sv
`timescale 1ns / 1ps
`include "vertex_weld_table_macros.svh"
module vwt_checker #(
	parameter int IDX_W = 10
) (
	input logic             clk,
	input logic             arst_n,
	input logic             in_valid,
	input logic             in_ready,
	input logic             out_valid,
	input logic             out_ready,
	input logic [IDX_W-1:0] out_index,
	input logic             out_added,
	input logic             out_full
);

	// one vertex in work at a time
	`VWT_ASSERT_NEXT(a_busy_after_transfer, clk, arst_n, in_valid && in_ready, !in_ready)
	`VWT_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid)
	`VWT_ASSERT_SAME(a_flags_excl, clk, arst_n, out_valid, !(out_added && out_full))
	`VWT_ASSERT_SAME(a_full_index, clk, arst_n, out_valid && out_full, out_index == '0)

endmodule

bind vertex_weld_table vwt_checker #(
	.IDX_W (IW)
) u_vwt_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (vertex_in.valid),
	.in_ready  (vertex_in.ready),
	.out_valid (result_out.valid),
	.out_ready (result_out.ready),
	.out_index (result_out.vertex_index),
	.out_added (result_out.added),
	.out_full  (result_out.table_full)
);
